// ===== rtl/core/das_pkg.sv =====
// ----------------------------------------------------------------------------
// das_pkg
// Shared constants and codes for the debug access splitter and its checker.
// ----------------------------------------------------------------------------
package das_pkg;

   // Request and link sizing
   localparam int MAX_BYTES  = 4096;
   localparam int BULK_WORDS = 7;
   localparam int PAGE_BYTES = 4096;

   localparam int LEN_W      = $clog2(MAX_BYTES + 1);
   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
   localparam int PAGE_NUM_W = 32 - PAGE_BITS;
   localparam int BULK_LIMIT = 4 * BULK_WORDS + 4;

   // Bulk write slots are 28 bytes; floor(x/28) = floor((x/4) * RECIP / 2^SHIFT)
   localparam int SLOT_BYTES = 28;
   localparam int SLOT_SHIFT = 17;
   localparam int SLOT_RECIP = ((1 << SLOT_SHIFT) + 6) / 7;

   // Volatile access flags
   localparam logic [7:0] FLAGS_WORD    = 8'hF8;
   localparam logic [7:0] FLAGS_HALF_LO = 8'hC8;
   localparam logic [7:0] FLAGS_HALF_HI = 8'h38;
   localparam logic [3:0] FLAGS_WR_BIT  = 4'h8;

   typedef enum logic [1:0] {
      OP_START_READ  = 2'd0,
      OP_START_WRITE = 2'd1,
      OP_NEXT        = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CMD_BULK_READ  = 3'd0,
      CMD_BULK_WRITE = 3'd1,
      CMD_SET_PAGE   = 3'd2,
      CMD_VOLATILE   = 3'd3,
      CMD_DONE       = 3'd4
   } cmd_type;

endpackage

// ===== rtl/core/debug_access_splitter.sv =====
// ----------------------------------------------------------------------------
// debug_access_splitter
// Splits a debug read or write into link commands, one per next item.
// ----------------------------------------------------------------------------
// A start item (read or write) loads address, length and direction and gives
// no result. Every next item gives exactly one command: bulk read, bulk write
// (preceded by a set page when the page changes or a new request begins),
// volatile word/halfword/byte access, or the done marker. Items are taken into
// an input register; the command is worked out from that register and the
// request state and lands in the result register at the next clock edge,
// and one item is taken every cycle as long as the result side keeps up. The
// result register lets the next item enter while a finished command is still
// waiting to be taken.
// ----------------------------------------------------------------------------
module debug_access_splitter
   import das_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_start_address,
   input  logic [12:0] req_byte_count,
   input  logic [31:0] req_next_bytes,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_command,
   output logic [31:0] rsp_bus_address,
   output logic [2:0]  rsp_word_count,
   output logic [7:0]  rsp_slot_index,
   output logic [7:0]  rsp_end_address_low,
   output logic [31:0] rsp_write_data,
   output logic [7:0]  rsp_access_flags,
   output logic [12:0] rsp_buffer_offset,
   output logic [4:0]  rsp_bytes_used,
   output logic        rsp_last
);

   localparam int SLOT_PROD_W = PAGE_BITS - 2 + 15;
   localparam int SLOT_CMP_W  = PAGE_BITS + 5;

   // Input register
   logic              s1_valid_ff;
   logic [1:0]        s1_op_ff;
   logic [31:0]       s1_addr_ff;
   logic [12:0]       s1_count_ff;
   logic [31:0]       s1_bytes_ff;

   // Request state
   logic [31:0]       cur_addr_ff, cur_addr_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic [PAGE_NUM_W-1:0] page_ff, page_in;
   logic              page_valid_ff, page_valid_in;
   logic              is_write_ff, is_write_in;
   logic              busy_ff, busy_in;

   // Result register
   logic              rsp_valid_ff;
   cmd_type           cmd_ff, cmd_in;
   logic [31:0]       addr_ff, addr_in;
   logic [2:0]        words_ff, words_in;
   logic [7:0]        slot_ff, slot_in;
   logic [7:0]        endlow_ff, endlow_in;
   logic [31:0]       data_ff, data_in;
   logic [7:0]        flags_ff, flags_in;
   logic [12:0]       boff_ff, boff_in;
   logic [4:0]        used_ff, used_in;
   logic              last_ff, last_in;

   // Handshake
   logic              out_free;
   logic              process;
   logic              load_rsp;

   // Shared command math
   logic [PAGE_BITS-1:0]   inpage;
   logic [PAGE_BITS:0]     room;
   logic [2:0]             n_raw;
   logic [2:0]             n_words;
   logic                   bulk_ok;
   logic [SLOT_PROD_W-1:0] slot_prod;
   logic [PAGE_BITS-1:0]   slot_q;
   logic                   slot_hit;
   logic [4:0]             used;
   logic [3:0]             lane_mask;
   logic [15:0]            half;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign process   = s1_valid_ff && (op_type'(s1_op_ff) != OP_NEXT || out_free);
   assign req_ready = !s1_valid_ff || process;

   // Bulk size: remaining length, then page room
   always_comb begin
      inpage = cur_addr_ff[PAGE_BITS-1:0];
      room   = (PAGE_BITS + 1)'(PAGE_BYTES) - (PAGE_BITS + 1)'(inpage);
      if (left_ff > LEN_W'(BULK_LIMIT)) begin
         n_raw = 3'(BULK_WORDS);
      end else begin
         n_raw = 3'(LEN_W'(left_ff >> 2) - LEN_W'(1));
      end
      if ((PAGE_BITS + 1)'({n_raw, 2'b00}) > room) begin
         n_words = 3'(room >> 2);
      end else begin
         n_words = n_raw;
      end
      bulk_ok = (left_ff >= LEN_W'(8)) && (n_words != 3'd0);
   end

   // In-page slot number by reciprocal multiply
   always_comb begin
      slot_prod = SLOT_PROD_W'(inpage >> 2) * SLOT_PROD_W'(SLOT_RECIP);
      slot_q    = PAGE_BITS'(slot_prod >> SLOT_SHIFT);
      slot_hit  = (SLOT_CMP_W'(slot_q) * SLOT_CMP_W'(SLOT_BYTES)) == SLOT_CMP_W'(inpage);
   end

   // Command selection and state update
   always_comb begin
      cur_addr_in   = cur_addr_ff;
      left_in       = left_ff;
      off_in        = off_ff;
      page_in       = page_ff;
      page_valid_in = page_valid_ff;
      is_write_in   = is_write_ff;
      busy_in       = busy_ff;

      load_rsp  = 1'b0;
      cmd_in    = CMD_DONE;
      addr_in   = cur_addr_ff;
      words_in  = '0;
      slot_in   = '0;
      endlow_in = '0;
      data_in   = '0;
      flags_in  = '0;
      boff_in   = 13'(off_ff);
      last_in   = 1'b0;
      used      = '0;
      lane_mask = 4'h8 >> cur_addr_ff[1:0];
      half      = s1_bytes_ff[31:16];

      if (process) begin
         unique case (op_type'(s1_op_ff)) inside
            OP_START_READ, OP_START_WRITE: begin
               cur_addr_in   = s1_addr_ff;
               left_in       = (32'(s1_count_ff) > 32'(MAX_BYTES)) ?
                               LEN_W'(MAX_BYTES) : LEN_W'(s1_count_ff);
               off_in        = '0;
               page_in       = '0;
               page_valid_in = 1'b0;
               is_write_in   = (op_type'(s1_op_ff) == OP_START_WRITE);
               busy_in       = 1'b1;
            end
            OP_NEXT: begin
               load_rsp = 1'b1;
               if (!busy_ff || left_ff == '0) begin
                  cmd_in  = CMD_DONE;
                  last_in = 1'b1;
                  busy_in = 1'b0;
               end else if (!is_write_ff) begin
                  if (cur_addr_ff[1:0] == 2'b00 && bulk_ok) begin
                     cmd_in    = CMD_BULK_READ;
                     words_in  = n_words;
                     endlow_in = cur_addr_ff[7:0] + 8'({n_words, 2'b00});
                     used      = {n_words, 2'b00};
                  end else begin
                     cmd_in  = CMD_VOLATILE;
                     addr_in = {cur_addr_ff[31:2], 2'b00};
                     used    = 5'd4 - 5'(cur_addr_ff[1:0]);
                     if (LEN_W'(used) > left_ff) begin
                        used = 5'(left_ff);
                     end
                  end
               end else begin
                  if (slot_hit && bulk_ok) begin
                     if (!page_valid_ff || page_ff != cur_addr_ff[31:PAGE_BITS]) begin
                        // page switch comes first, no bytes consumed
                        cmd_in        = CMD_SET_PAGE;
                        addr_in       = {cur_addr_ff[31:PAGE_BITS], PAGE_BITS'(0)};
                        page_in       = cur_addr_ff[31:PAGE_BITS];
                        page_valid_in = 1'b1;
                     end else begin
                        cmd_in   = CMD_BULK_WRITE;
                        words_in = n_words;
                        slot_in  = 8'(slot_q);
                        used     = {n_words, 2'b00};
                     end
                  end else if (cur_addr_ff[1:0] == 2'b00 && left_ff >= LEN_W'(4)) begin
                     cmd_in   = CMD_VOLATILE;
                     addr_in  = {cur_addr_ff[31:2], 2'b00};
                     data_in  = s1_bytes_ff;
                     flags_in = FLAGS_WORD;
                     used     = 5'd4;
                  end else if (!cur_addr_ff[0] && left_ff >= LEN_W'(2)) begin
                     cmd_in   = CMD_VOLATILE;
                     addr_in  = {cur_addr_ff[31:2], 2'b00};
                     data_in  = {half, half};
                     flags_in = cur_addr_ff[1] ? FLAGS_HALF_HI : FLAGS_HALF_LO;
                     used     = 5'd2;
                  end else begin
                     cmd_in   = CMD_VOLATILE;
                     addr_in  = {cur_addr_ff[31:2], 2'b00};
                     data_in  = {4{s1_bytes_ff[31:24]}};
                     flags_in = {lane_mask, FLAGS_WR_BIT};
                     used     = 5'd1;
                  end
               end
               cur_addr_in = cur_addr_ff + 32'(used);
               left_in     = left_ff - LEN_W'(used);
               off_in      = off_ff + LEN_W'(used);
            end
            default: begin
            end
         endcase
      end
      used_in = used;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (process) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         s1_op_ff    <= req_operation;
         s1_addr_ff  <= req_start_address;
         s1_count_ff <= req_byte_count;
         s1_bytes_ff <= req_next_bytes;
      end
   end

   // Request state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff   <= '0;
         left_ff       <= '0;
         off_ff        <= '0;
         page_ff       <= '0;
         page_valid_ff <= 1'b0;
         is_write_ff   <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         cur_addr_ff   <= cur_addr_in;
         left_ff       <= left_in;
         off_ff        <= off_in;
         page_ff       <= page_in;
         page_valid_ff <= page_valid_in;
         is_write_ff   <= is_write_in;
         busy_ff       <= busy_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         cmd_ff    <= cmd_in;
         addr_ff   <= addr_in;
         words_ff  <= words_in;
         slot_ff   <= slot_in;
         endlow_ff <= endlow_in;
         data_ff   <= data_in;
         flags_ff  <= flags_in;
         boff_ff   <= boff_in;
         used_ff   <= used_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command         = cmd_ff;
   assign rsp_bus_address     = addr_ff;
   assign rsp_word_count      = words_ff;
   assign rsp_slot_index      = slot_ff;
   assign rsp_end_address_low = endlow_ff;
   assign rsp_write_data      = data_ff;
   assign rsp_access_flags    = flags_ff;
   assign rsp_buffer_offset   = boff_ff;
   assign rsp_bytes_used      = used_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== rtl/core/das_checker.sv =====
// ----------------------------------------------------------------------------
// das_checker
// Port-level checks for the debug access splitter, bound to every splitter instance.
// ----------------------------------------------------------------------------
module das_checker
   import das_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_command,
   input logic [31:0] rsp_bus_address,
   input logic [2:0]  rsp_word_count,
   input logic [4:0]  rsp_bytes_used,
   input logic        rsp_last
);

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   // Done marker and last flag go together
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_command == CMD_DONE)))
      else $error("last flag and done marker disagree");

   // Bulk commands move at least one word and consume exactly their words
   a_bulk_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_BULK_READ || rsp_command == CMD_BULK_WRITE)
      |-> rsp_word_count != 3'd0 && rsp_bytes_used == {rsp_word_count, 2'b00})
      else $error("bulk word count and bytes used mismatch");

   // Set page names a page base and consumes nothing
   a_set_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_SET_PAGE
      |-> rsp_bus_address[PAGE_BITS-1:0] == '0 && rsp_bytes_used == 5'd0)
      else $error("set page word is not a clean page base");

   // A stalled result word holds its valid, address and command
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_address)
      && $stable(rsp_command))
      else $error("stalled result word changed");

endmodule

bind debug_access_splitter das_checker u_das_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_command     (rsp_command),
   .rsp_bus_address (rsp_bus_address),
   .rsp_word_count  (rsp_word_count),
   .rsp_bytes_used  (rsp_bytes_used),
   .rsp_last        (rsp_last)
);

// ===== test/splitter_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// splitter_tb_pkg
// Command prediction and checking for the debug access splitter testbench.
// ----------------------------------------------------------------------------
// The ledger keeps its own copy of the request state (address, bytes left,
// bytes consumed, loaded page, direction, busy). Every accepted start or next
// word updates that state. A next word also queues the link command it must
// produce. Result words from the block are matched against the oldest queued
// command, field by field.
// ----------------------------------------------------------------------------
package splitter_tb_pkg;
   import das_pkg::*;

   // Operation code that the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] bus_address;
      logic [2:0]  word_count;
      logic [7:0]  slot_index;
      logic [7:0]  end_address_low;
      logic [31:0] write_data;
      logic [7:0]  access_flags;
      logic [12:0] buffer_offset;
      logic [4:0]  bytes_used;
      logic        last;
   } link_cmd_type;

   class command_ledger;
      // request state
      logic [31:0] addr_now   = '0;
      int unsigned remain     = 0;
      int unsigned consumed   = 0;
      logic [19:0] page_held  = '0;
      bit          page_set   = 1'b0;
      bit          writing    = 1'b0;
      bit          active     = 1'b0;

      link_cmd_type owed_cmds[$];
      int          errors     = 0;
      int          starts     = 0;
      int          restarts   = 0;
      int          ignored    = 0;
      int          kind_seen[5];

      // Words a bulk command may move from here, clipped at the page end
      function int unsigned bulk_span();
         int unsigned n;
         int unsigned room;
         if (remain > BULK_LIMIT) n = BULK_WORDS;
         else n = (remain - 4) / 4;
         room = PAGE_BYTES - (addr_now % PAGE_BYTES);
         if (n * 4 > room) n = room / 4;
         return n;
      endfunction

      function void step_on(int unsigned used);
         addr_now = addr_now + used;
         remain   = remain - used;
         consumed = consumed + used;
      endfunction

      // Command that a next word produces from the present state
      function link_cmd_type next_command(logic [31:0] nb);
         link_cmd_type c;
         int unsigned n;
         int unsigned used;
         int unsigned inpage;
         logic [15:0] half;
         logic [3:0]  mask;
         c = '0;
         c.buffer_offset = consumed[12:0];

         // idle or used up: done marker
         if (!active || remain == 0) begin
            c.command = CMD_DONE;
            c.bus_address = addr_now;
            c.last = 1'b1;
            active = 1'b0;
            return c;
         end

         if (!writing) begin
            n = (addr_now[1:0] == 2'd0 && remain >= 8) ? bulk_span() : 0;
            if (n != 0) begin
               c.command = CMD_BULK_READ;
               c.bus_address = addr_now;
               c.word_count = n[2:0];
               c.end_address_low = addr_now[7:0] + 8'(n * 4);
               c.bytes_used = 5'(n * 4);
               step_on(n * 4);
            end else begin
               used = 4 - addr_now[1:0];
               if (remain < used) used = remain;
               c.command = CMD_VOLATILE;
               c.bus_address = {addr_now[31:2], 2'b00};
               c.bytes_used = 5'(used);
               step_on(used);
            end
            return c;
         end

         inpage = addr_now % PAGE_BYTES;
         n = (inpage % SLOT_BYTES == 0 && remain >= 8) ? bulk_span() : 0;
         if (n != 0) begin
            if (!page_set || page_held != addr_now[31:12]) begin
               // new page or new request: load the page first
               c.command = CMD_SET_PAGE;
               c.bus_address = addr_now - inpage;
               page_held = addr_now[31:12];
               page_set = 1'b1;
            end else begin
               c.command = CMD_BULK_WRITE;
               c.bus_address = addr_now;
               c.word_count = n[2:0];
               c.slot_index = 8'(inpage / SLOT_BYTES);
               c.bytes_used = 5'(n * 4);
               step_on(n * 4);
            end
         end else if (addr_now[1:0] == 2'd0 && remain >= 4) begin
            c.command = CMD_VOLATILE;
            c.bus_address = addr_now;
            c.write_data = nb;
            c.access_flags = FLAGS_WORD;
            c.bytes_used = 5'd4;
            step_on(4);
         end else if (addr_now[0] == 1'b0 && remain >= 2) begin
            half = nb[31:16];
            c.command = CMD_VOLATILE;
            c.bus_address = {addr_now[31:2], 2'b00};
            c.write_data = {half, half};
            c.access_flags = addr_now[1] ? FLAGS_HALF_HI : FLAGS_HALF_LO;
            c.bytes_used = 5'd2;
            step_on(2);
         end else begin
            mask = 4'h8 >> addr_now[1:0];
            c.command = CMD_VOLATILE;
            c.bus_address = {addr_now[31:2], 2'b00};
            c.write_data = {4{nb[31:24]}};
            c.access_flags = {mask, FLAGS_WR_BIT};
            c.bytes_used = 5'd1;
            step_on(1);
         end
         return c;
      endfunction

      // Accepted request word
      function void take_item(logic [1:0] op, logic [31:0] addr, logic [12:0] cnt,
                              logic [31:0] nb);
         if (op == OP_START_READ || op == OP_START_WRITE) begin
            if (active && remain != 0) restarts++;
            addr_now = addr;
            remain = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
            consumed = 0;
            page_set = 1'b0;
            page_held = '0;
            writing = (op == OP_START_WRITE);
            active = 1'b1;
            starts++;
         end else if (op == OP_NEXT) begin
            owed_cmds.push_back(next_command(nb));
         end else begin
            ignored++;
         end
      endfunction

      function void cmp(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      // Accepted result word
      function void match_command(link_cmd_type seen);
         link_cmd_type want;
         if (owed_cmds.size() == 0) begin
            $error("command: unexpected word %0h at address %0h", seen.command,
                   seen.bus_address);
            errors++;
            return;
         end
         want = owed_cmds.pop_front();
         kind_seen[want.command]++;
         cmp("command", want.command, seen.command);
         cmp("bus_address", want.bus_address, seen.bus_address);
         cmp("word_count", want.word_count, seen.word_count);
         cmp("slot_index", want.slot_index, seen.slot_index);
         cmp("end_address_low", want.end_address_low, seen.end_address_low);
         cmp("write_data", want.write_data, seen.write_data);
         cmp("access_flags", want.access_flags, seen.access_flags);
         cmp("buffer_offset", want.buffer_offset, seen.buffer_offset);
         cmp("bytes_used", want.bytes_used, seen.bytes_used);
         cmp("last", want.last, seen.last);
      endfunction

      function int pending();
         return owed_cmds.size();
      endfunction
   endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the debug access splitter.
// ----------------------------------------------------------------------------
// Drives start, next and unused request words over the valid/ready request
// port, with random gaps on both sides and one long hold-off on the result
// side. A directed part hits zero length, idle next, length saturation,
// address wrap, page boundaries and byte/halfword/word writes; a random part
// runs mostly complete requests with random content, mixed with abandoned
// requests, stray next words and unused codes. Every result word is checked
// against the ledger's predicted command.
// ----------------------------------------------------------------------------
module tb_top;
   import das_pkg::*;
   import splitter_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1050;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN       = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_NEXT;
   logic [31:0] req_start_address = '0;
   logic [12:0] req_byte_count = '0;
   logic [31:0] req_next_bytes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_command;
   logic [31:0] rsp_bus_address;
   logic [2:0]  rsp_word_count;
   logic [7:0]  rsp_slot_index;
   logic [7:0]  rsp_end_address_low;
   logic [31:0] rsp_write_data;
   logic [7:0]  rsp_access_flags;
   logic [12:0] rsp_buffer_offset;
   logic [4:0]  rsp_bytes_used;
   logic        rsp_last;

   command_ledger ledger;
   int words_sent = 0;
   int cmds_taken = 0;
   int stall_cycles = 0;

   debug_access_splitter uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_start_address  (req_start_address),
      .req_byte_count     (req_byte_count),
      .req_next_bytes     (req_next_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_bus_address    (rsp_bus_address),
      .rsp_word_count     (rsp_word_count),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_end_address_low(rsp_end_address_low),
      .rsp_write_data     (rsp_write_data),
      .rsp_access_flags   (rsp_access_flags),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_bytes_used     (rsp_bytes_used),
      .rsp_last           (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle cycles before a word; every third stretch runs with no idling
   function automatic int idle_draw(int count);
      if ((count / 70) % 3 == 1) return 0;
      return $urandom_range(0, 18);
   endfunction

   // Offer one request word and hold it until accepted
   task automatic send_item(logic [1:0] op, logic [31:0] addr, logic [12:0] cnt,
                            logic [31:0] nb);
      int gap;
      gap = idle_draw(words_sent);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_start_address <= addr;
      req_byte_count <= cnt;
      req_next_bytes <= nb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.take_item(op, addr, cnt, nb);
      words_sent++;
   endtask

   task automatic send_next();
      logic [31:0] nb;
      case ($urandom_range(0, 9))
         0: nb = '0;
         1: nb = '1;
         default: nb = $urandom;
      endcase
      send_item(OP_NEXT, $urandom, 13'($urandom), nb);
   endtask

   function automatic logic [31:0] pick_address();
      logic [31:0] page;
      page = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4: return page + SLOT_BYTES * $urandom_range(0, 146) + $urandom_range(0, 3);
         5, 6: return page + PAGE_BYTES - $urandom_range(1, 40);
         7: return 32'hFFFFFFFF - $urandom_range(0, 40);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Mostly short requests; a few full-size and oversized ones
   function automatic logic [12:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 13'($urandom_range(0, 16));
      if (r < 75) return 13'($urandom_range(17, 120));
      if (r < 90) return 13'($urandom_range(121, 600));
      if (r < 94) return 13'(MAX_BYTES);
      if (r < 97) return 13'($urandom_range(601, MAX_BYTES));
      return 13'($urandom_range(MAX_BYTES + 1, 8191));
   endfunction

   task automatic run_directed();
      // zero length, then next while idle, then an unused code
      send_item(OP_START_READ, '0, '0, '0);
      send_item(OP_NEXT, '0, '0, '0);
      send_item(OP_NEXT, '1, '1, '1);
      send_item(OP_UNUSED, '1, '1, '1);
      // oversized write across the address wrap, abandoned midway
      send_item(OP_START_WRITE, 32'hFFFFFFFE, 13'h1FFF, '1);
      send_item(OP_NEXT, '0, '0, 32'hFFFFFFFF);
      send_item(OP_NEXT, '0, '0, 32'h00000000);
      send_item(OP_NEXT, '0, '0, 32'hA5C35A3C);
      send_item(OP_NEXT, '0, '0, 32'h5A3CA5C3);
      send_item(OP_NEXT, '0, '0, 32'h12345678);
      // read that crosses a page end
      send_item(OP_START_READ, 32'h00000FF5, 13'd20, '0);
      repeat (6) send_next();
      // byte, upper halfword, word, then done
      send_item(OP_START_WRITE, 32'h00002001, 13'd7, '0);
      send_item(OP_NEXT, '0, '0, 32'h817E00FF);
      send_item(OP_NEXT, '0, '0, 32'hC33C0000);
      send_item(OP_NEXT, '0, '0, 32'hDEADBEEF);
      send_item(OP_NEXT, '0, '0, 32'h00000000);
   endtask

   task automatic run_random();
      int r;
      int steps;
      int quit_at;
      while (words_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(OP_UNUSED, $urandom, 13'($urandom), $urandom);
         end else if (r < 8) begin
            send_next();
         end else begin
            send_item($urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ,
                      pick_address(), pick_length(), $urandom);
            quit_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1;
            steps = 0;
            // run the request to its done marker unless it is abandoned
            while (ledger.active && steps != quit_at && words_sent < ITEM_TARGET) begin
               send_next();
               steps++;
            end
         end
      end
   endtask

   // Result side: random stalls, one long hold-off while the sender keeps going
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_draw(cmds_taken);
         if (cmds_taken >= HOLD_AT && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      link_cmd_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.command = cmd_type'(rsp_command);
         seen.bus_address = rsp_bus_address;
         seen.word_count = rsp_word_count;
         seen.slot_index = rsp_slot_index;
         seen.end_address_low = rsp_end_address_low;
         seen.write_data = rsp_write_data;
         seen.access_flags = rsp_access_flags;
         seen.buffer_offset = rsp_buffer_offset;
         seen.bytes_used = rsp_bytes_used;
         seen.last = rsp_last;
         ledger.match_command(seen);
         cmds_taken <= cmds_taken + 1;
      end
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (ledger.pending() > 0) begin
         $error("last: %0d commands never arrived", ledger.pending());
         ledger.errors++;
      end
      $display("covered %0d requests (%0d cut short), %0d unused codes, %0d words sent",
               ledger.starts, ledger.restarts, ledger.ignored, words_sent);
      $display("commands: %0d bulk read, %0d bulk write, %0d set page, %0d volatile, %0d done",
               ledger.kind_seen[CMD_BULK_READ], ledger.kind_seen[CMD_BULK_WRITE],
               ledger.kind_seen[CMD_SET_PAGE], ledger.kind_seen[CMD_VOLATILE],
               ledger.kind_seen[CMD_DONE]);
      if (ledger.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
